FILE: design/mcfb_pkg.sv
package mcfb_pkg;

  localparam int unsigned FIFO_DEPTH = 2;

  localparam logic [7:0]  START_BYTE = 8'hFF;
  localparam logic [7:0]  LEN_BYTE   = 8'h07;
  localparam logic [8:0]  SPEED_MOD  = 9'd241;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;

  // One classified command, waiting for the byte serializer.
  typedef struct packed {
    logic [7:0] left_mag;
    logic [7:0] right_mag;
    logic       left_fwd;
    logic       right_fwd;
  } cmd_t;

  // Position within the nine-byte frame.
  typedef enum logic [3:0] {
    POS_START,
    POS_LEN,
    POS_LEFT,
    POS_ZERO_A,
    POS_RIGHT,
    POS_ZERO_B,
    POS_FLAGS,
    POS_CRC_LO,
    POS_CRC_HI
  } frame_pos_t;

  // Reflected CRC-16 update over one byte.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

FILE: design/mcfb_front.sv
module mcfb_front
  import mcfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_left_speed,
  input  logic signed [15:0] in_right_speed,
  output logic               q_push,
  output cmd_t               q_cmd,
  input  logic               q_full
);

  // 256 mod 241 = 15, so fold the high byte down as hi*15 + lo.
  function automatic logic [11:0] fold_hi(input logic [15:0] raw);
    logic [15:0] mag;
    logic [11:0] hi;
    mag = raw[15] ? (~raw + 16'd1) : raw;
    hi  = {4'b0000, mag[15:8]};
    return (hi << 4) - hi + {4'b0000, mag[7:0]};
  endfunction

  // Second fold leaves a value below 2*241; one compare and subtract finishes.
  function automatic logic [7:0] fold_lo(input logic [11:0] f);
    logic [8:0] hi;
    logic [8:0] s;
    hi = {5'b00000, f[11:8]};
    s  = (hi << 4) - hi + {1'b0, f[7:0]};
    if (s >= SPEED_MOD) begin
      s = s - SPEED_MOD;
    end
    return s[7:0];
  endfunction

  logic        stage_valid_r, stage_valid_nxt;
  logic [11:0] left_fold_r, right_fold_r;
  logic        left_fwd_r, right_fwd_r;
  logic        accept;

  assign in_full = stage_valid_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = stage_valid_r && !q_full;

  always_comb begin
    q_cmd.left_mag  = fold_lo(left_fold_r);
    q_cmd.right_mag = fold_lo(right_fold_r);
    q_cmd.left_fwd  = left_fwd_r;
    q_cmd.right_fwd = right_fwd_r;
  end

  always_comb begin
    stage_valid_nxt = stage_valid_r;
    if (accept) begin
      stage_valid_nxt = 1'b1;
    end else if (q_push) begin
      stage_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      left_fold_r  <= fold_hi(in_left_speed);
      right_fold_r <= fold_hi(in_right_speed);
      left_fwd_r   <= (in_left_speed != 16'sd0) && !in_left_speed[15];
      right_fwd_r  <= (in_right_speed != 16'sd0) && !in_right_speed[15];
    end
  end

endmodule

FILE: design/mcfb_fifo.sv
module mcfb_fifo
  import mcfb_pkg::*;
#(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;

  assign full  = (count_r == CntW'(Depth));
  assign empty = (count_r == '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule

FILE: design/mcfb_back.sv
module mcfb_back
  import mcfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       q_head,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  frame_pos_t  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r;
  logic        out_last_r;
  logic [7:0]  cur_byte;
  logic        advance;

  assign advance        = !q_empty && (!out_valid_r || out_pop);
  assign q_pop          = advance && (pos_r == POS_CRC_HI);
  assign out_empty      = !out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  // Next position.
  always_comb begin
    pos_nxt = pos_r;
    if (advance) begin
      case (pos_r)
        POS_START:  pos_nxt = POS_LEN;
        POS_LEN:    pos_nxt = POS_LEFT;
        POS_LEFT:   pos_nxt = POS_ZERO_A;
        POS_ZERO_A: pos_nxt = POS_RIGHT;
        POS_RIGHT:  pos_nxt = POS_ZERO_B;
        POS_ZERO_B: pos_nxt = POS_FLAGS;
        POS_FLAGS:  pos_nxt = POS_CRC_LO;
        POS_CRC_LO: pos_nxt = POS_CRC_HI;
        POS_CRC_HI: pos_nxt = POS_START;
        default:    pos_nxt = POS_START;
      endcase
    end
  end

  // Byte for the current position.
  always_comb begin
    case (pos_r)
      POS_START:  cur_byte = START_BYTE;
      POS_LEN:    cur_byte = LEN_BYTE;
      POS_LEFT:   cur_byte = q_head.left_mag;
      POS_RIGHT:  cur_byte = q_head.right_mag;
      POS_FLAGS:  cur_byte = {1'b0, q_head.left_fwd, 1'b0, q_head.right_fwd, 4'b0000};
      POS_CRC_LO: cur_byte = crc_r[7:0];
      POS_CRC_HI: cur_byte = crc_r[15:8];
      default:    cur_byte = 8'h00;
    endcase
  end

  // Seed on the start byte, fold in length through flags.
  always_comb begin
    crc_nxt = crc_r;
    if (advance) begin
      case (pos_r)
        POS_START:  crc_nxt = CRC_INIT;
        POS_LEN,
        POS_LEFT,
        POS_ZERO_A,
        POS_RIGHT,
        POS_ZERO_B,
        POS_FLAGS:  crc_nxt = crc_update(crc_r, cur_byte);
        default:    crc_nxt = crc_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_START;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (advance) begin
      out_byte_r <= cur_byte;
      out_last_r <= (pos_r == POS_CRC_HI);
    end
  end

  a_mid_frame_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != POS_START) |-> !q_empty)
    else $error("serializer mid-frame without a queued command");

  a_crc_seeded: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == POS_LEN) |-> (crc_r == CRC_INIT))
    else $error("crc not seeded after start byte");

  a_last_closes_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (pos_r == POS_START))
    else $error("last word shown while serializer is mid-frame");

endmodule

FILE: design/motor_command_frame_builder.sv
// The first frame word passes the front stage, the command queue and the output register.
// Throughput: one nine-word frame per command, one word per cycle while out_pop stays high;
//   the byte-wide result port fed from the serializer's output register bounds it.
// Reset (rst_n low, synchronous): the front stage, command queue and serializer empty,
//   and the serializer returns to the start of a frame; data registers keep their contents.
module motor_command_frame_builder
  import mcfb_pkg::*;
#(
  parameter int unsigned QueueDepth = FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_left_speed,
  input  logic signed [15:0] in_right_speed,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_frame_byte,
  output logic               out_last_byte
);

  // Front: take a command, reduce both speed magnitudes mod 241, grab direction flags.
  // Queue: hold classified commands so intake and serializing stall independently.
  // Back: walk the nine frame positions, CRC length through flags, register the output.

  cmd_t q_push_cmd;
  cmd_t q_head;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;

  mcfb_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_left_speed  (in_left_speed),
    .in_right_speed (in_right_speed),
    .q_push         (q_push),
    .q_cmd          (q_push_cmd),
    .q_full         (q_full)
  );

  mcfb_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Drop the queue head only after the closing CRC word is loaded.
  mcfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

FILE: sim/tb_motor_command_frame_builder.sv
`timescale 1ns / 100ps

module tb_motor_command_frame_builder;
  import mcfb_pkg::*;

  localparam int unsigned FRAME_WORDS   = 9;
  localparam int unsigned LEFT_FWD_BIT  = 6;
  localparam int unsigned RIGHT_FWD_BIT = 4;
  localparam int unsigned RESET_CYCLES  = 4;
  // Allow generous slack at the end to catch any stray word.
  localparam int unsigned TAIL_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned CYCLE_LIMIT   = 300000;

  // One word of a drive frame as it leaves the block.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } frame_word_t;

  typedef logic [FRAME_WORDS-1:0][7:0] drive_frame_t;

  logic               clk;
  logic               rst_n          = 1'b0;
  logic               in_push        = 1'b0;
  logic               in_full;
  logic signed [15:0] in_left_speed  = '0;
  logic signed [15:0] in_right_speed = '0;
  logic               out_empty;
  logic               out_pop        = 1'b0;
  logic [7:0]         out_frame_byte;
  logic               out_last_byte;

  // Words predicted for accepted commands, oldest first.
  frame_word_t pending_words[$];

  int unsigned max_send_gap  = 10;
  int unsigned max_pop_gap   = 10;
  int unsigned pop_hold_left = 0;
  int unsigned error_count   = 0;
  int unsigned commands_sent = 0;
  int unsigned words_checked = 0;
  int unsigned full_stalls   = 0;
  int unsigned cycle_count   = 0;

  motor_command_frame_builder i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_left_speed (in_left_speed),
    .in_right_speed(in_right_speed),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_frame_byte(out_frame_byte),
    .out_last_byte (out_last_byte)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Bound the run: a hang anywhere ends here.
  initial begin
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles, %0d words still expected",
                 cycle_count, pending_words.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Count down the receiver hold-off; tests load it only while it is zero.
  always @(posedge clk) begin
    if (pop_hold_left != 0) pop_hold_left <= pop_hold_left - 1;
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $time, msg);
  endtask

  // Magnitude of a signed speed folded into one byte (mod 241).
  function automatic logic [7:0] speed_residue(input logic signed [15:0] speed);
    int mag;
    mag = (speed < 0) ? -int'(speed) : int'(speed);
    return 8'(mag % int'(SPEED_MOD));
  endfunction

  // Reflected CRC-16 over frame bytes one to six, fed one bit at a time, LSB first.
  function automatic logic [15:0] frame_crc(input drive_frame_t frame);
    logic [15:0] acc;
    logic        fb;
    acc = CRC_INIT;
    for (int k = 1; k <= 6; k++) begin
      for (int b = 0; b < 8; b++) begin
        fb  = acc[0] ^ frame[k][b];
        acc = acc >> 1;
        if (fb) acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic drive_frame_t build_drive_frame(input logic signed [15:0] left,
                                                     input logic signed [15:0] right);
    drive_frame_t frame;
    logic [15:0]  crc;
    frame    = '0;
    frame[0] = START_BYTE;
    frame[1] = LEN_BYTE;
    frame[2] = speed_residue(left);
    frame[4] = speed_residue(right);
    // Zero speed counts as reverse: only a strictly positive speed sets its bit.
    frame[6][LEFT_FWD_BIT]  = (left > 0);
    frame[6][RIGHT_FWD_BIT] = (right > 0);
    crc      = frame_crc(frame);
    frame[7] = crc[7:0];
    frame[8] = crc[15:8];
    return frame;
  endfunction

  // Mix of full-range values, small speeds and values near multiples of 241.
  function automatic logic signed [15:0] random_speed();
    logic signed [15:0] speed;
    case ($urandom_range(0, 4))
      0, 1: speed = 16'($urandom);
      2: speed = 16'($urandom_range(0, 600));
      3: speed = 16'(241 * $urandom_range(0, 135) + $urandom_range(0, 2) - 1);
      default: begin
        case ($urandom_range(0, 3))
          0: speed = 16'sh7FFF;
          1: speed = 16'sh8000;
          2: speed = 16'sh0000;
          default: speed = 16'sh8001;
        endcase
      end
    endcase
    if ($urandom_range(0, 1)) speed = -speed;
    return speed;
  endfunction

  // Offer one command after a random gap and hold it until accepted. Push stays high
  // on return so that a back-to-back command needs no second assignment this step.
  task automatic send_speeds(input logic signed [15:0] left, input logic signed [15:0] right);
    drive_frame_t frame;
    int unsigned  gap;
    gap = $urandom_range(0, max_send_gap);
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push        <= 1'b1;
    in_left_speed  <= left;
    in_right_speed <= right;
    @(posedge clk);
    while (in_full !== 1'b0) begin
      full_stalls++;
      @(posedge clk);
    end
    frame = build_drive_frame(left, right);
    for (int k = 0; k < FRAME_WORDS; k++) begin
      pending_words.push_back('{frame_byte: frame[k], last_byte: (k == FRAME_WORDS - 1)});
    end
    commands_sent++;
  endtask

  // Drop push and hold until every predicted word has been popped.
  task automatic wait_for_drain();
    in_push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls per word, plus any hold-off a test has loaded.
  initial begin : word_receiver
    frame_word_t want;
    int unsigned stall;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = $urandom_range(0, max_pop_gap);
      if (stall != 0 || pop_hold_left != 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(posedge clk);
        while (pop_hold_left != 0) @(posedge clk);
      end
      out_pop <= 1'b1;
      @(posedge clk);
      while (out_empty !== 1'b0) @(posedge clk);
      words_checked++;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("word 0x%02h last=%0b with nothing expected",
                                  out_frame_byte, out_last_byte));
      end else begin
        want = pending_words.pop_front();
        if (out_frame_byte !== want.frame_byte) begin
          report_mismatch($sformatf("frame_byte 0x%02h, expected 0x%02h",
                                    out_frame_byte, want.frame_byte));
        end
        if (out_last_byte !== want.last_byte) begin
          report_mismatch($sformatf("last_byte %0b, expected %0b (byte 0x%02h)",
                                    out_last_byte, want.last_byte, want.frame_byte));
        end
      end
    end
  end

  // Extremes of both fields, zero, the most negative speed and residue boundaries.
  task automatic test_directed_extremes();
    send_speeds(0, 0);
    send_speeds(32767, 32767);
    send_speeds(-32768, -32768);
    send_speeds(-32768, 32767);
    send_speeds(1, -1);
    send_speeds(-1, 1);
    send_speeds(240, -240);
    send_speeds(241, -241);
    send_speeds(242, 482);
    send_speeds(-32767, 0);
    send_speeds(0, -32768);
    send_speeds(16'sh5555, 16'shAAAA);
    send_speeds(16'shAAAA, 16'sh5555);
    send_speeds(32767, -32768);
    wait_for_drain();
  endtask

  // Run both sides without idling to hit back-to-back frames at full rate.
  task automatic test_full_rate();
    max_send_gap = 0;
    max_pop_gap  = 0;
    repeat (20) send_speeds(random_speed(), random_speed());
    wait_for_drain();
    max_send_gap = 10;
    max_pop_gap  = 10;
  endtask

  // Hold the receiver off for a long stretch while commands keep coming, so the
  // block fills up and raises full.
  task automatic test_fill_and_stall();
    max_send_gap = 0;
    pop_hold_left <= HOLD_CYCLES;
    repeat (12) send_speeds(random_speed(), random_speed());
    wait_for_drain();
    max_send_gap = 10;
  endtask

  // Pause the sender until the block has drained, then resume.
  task automatic test_sender_pause();
    repeat (10) send_speeds(random_speed(), random_speed());
    wait_for_drain();
    repeat (10) send_speeds(random_speed(), random_speed());
    wait_for_drain();
  endtask

  task automatic test_random_commands();
    repeat (170) send_speeds(random_speed(), random_speed());
    wait_for_drain();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_full_rate();
    test_fill_and_stall();
    test_sender_pause();
    test_random_commands();

    // Catch any stray word after the last frame.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d drive commands, %0d frame words checked, %0d cycles with input full",
             commands_sent, words_checked, full_stalls);
    $display("Included speed extremes, full-rate bursts, a long receiver hold-off and a drain pause");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: motor_command_frame_builder.f
design/mcfb_pkg.sv
design/mcfb_front.sv
design/mcfb_fifo.sv
design/mcfb_back.sv
design/motor_command_frame_builder.sv
sim/tb_motor_command_frame_builder.sv
